>>> hdl/sweb_pkg.sv
// Shared constants and helpers for the smoothed windowed extremum baseline block.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package sweb_pkg;

  localparam int DATA_W       = 32;
  localparam int GAIN_W       = 17;
  localparam int SEGMENTS_DEF = 16;

  // Configuration port geometry: three registers on a 32-bit port at byte addresses 0, 4 and 8.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(6554);
  localparam logic [DATA_W-1:0] PERIOD_RST = DATA_W'(60000);

  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = 3 * DATA_W;
  localparam int OUT_TUSER_W = 3;

  // Extremum rule: mode 0 keeps the minimum, mode 1 the maximum; a wins ties.
  function automatic logic signed [DATA_W-1:0] pick(input logic mode,
                                                    input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic take_b;
    take_b = mode ? (b > a) : (b < a);
    return take_b ? b : a;
  endfunction

endpackage

>>> hdl/smoothed_windowed_extremum_baseline.sv
// An input word is taken only in the idle state and passes through the multiply, filter and
// fold states to the output state, which registers the result; a word that closes a segment
// first passes the scan state, rebuilding the baseline by reading one ring slot per cycle.
// Reset (rst_n low, synchronous) restores the register defaults, clears the smoother,
// the open segment, the baseline and every slot valid bit; the ring memory itself is
// left as it is and needs no clearing pass.
`timescale 1ns / 1ps

module smoothed_windowed_extremum_baseline #(
  parameter int SEGMENTS = sweb_pkg::SEGMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sweb_pkg::IN_TDATA_W-1:0]  in_tdata,   // sample[31:0], now_ms[63:32]
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // smoothed[31:0], segment_extremum[63:32], baseline[95:64]
  output logic [sweb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // segment_extremum_valid[0], baseline_valid[1], segment_closed[2]
  output logic [sweb_pkg::OUT_TUSER_W-1:0] out_tuser,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sweb_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [sweb_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [sweb_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  import sweb_pkg::*;

  localparam int IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEGMENTS - 1);
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int DELTA_W = PROD_W - 16;
  localparam int SUM_W = DELTA_W + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_FILT = 6'b000100,
    S_FOLD = 6'b001000,
    S_SCAN = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_r;
  logic [DATA_W-1:0] period_r;
  logic              mode_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  // Item and block state.
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0]        now_r, now_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DATA_W-1:0] filt_r, filt_nxt;
  logic                     filt_valid_r, filt_valid_nxt;
  logic signed [DATA_W-1:0] open_r, open_nxt;
  logic                     open_valid_r, open_valid_nxt;
  logic signed [DATA_W-1:0] base_r, base_nxt;
  logic                     base_valid_r, base_valid_nxt;
  logic [SEGMENTS-1:0]      ring_valid_r, ring_valid_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [DATA_W-1:0]        last_close_r, last_close_nxt;
  logic                     closed_r, closed_nxt;

  // Baseline scan over the ring.
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             scan_issue_r, scan_issue_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Ring memory ports.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Datapath helpers.
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   y_wide;
  logic signed [DATA_W-1:0]  y_sat;
  logic signed [DATA_W-1:0]  ext_new;
  logic [DATA_W-1:0]         elapsed;
  logic                      close;
  logic signed [DATA_W-1:0]  seg_out;

  sweb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SEGMENTS)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration port: writes land in the access phase, reads are combinational.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_GAIN:   cfg_prdata = CFG_DW'(gain_r);
      REG_PERIOD: cfg_prdata = period_r;
      REG_MODE:   cfg_prdata = CFG_DW'(mode_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      period_r <= PERIOD_RST;
      mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN:   gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_PERIOD: period_r <= cfg_pwdata[DATA_W-1:0];
        REG_MODE:   mode_r   <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  // Smoother arithmetic: the product is registered, rounding and saturation follow.
  assign diff     = DIFF_W'(filt_r) - DIFF_W'(x_r);
  assign prod_rnd = prod_r + PROD_W'(32768);
  assign delta    = DELTA_W'(prod_rnd >>> 16);
  assign y_wide   = SUM_W'(filt_r) - SUM_W'(delta);

  always_comb begin
    if (y_wide[SUM_W-1:DATA_W-1] == '0 || y_wide[SUM_W-1:DATA_W-1] == '1) begin
      y_sat = y_wide[DATA_W-1:0];
    end else if (y_wide[SUM_W-1]) begin
      y_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign ext_new = open_valid_r ? pick(mode_r, open_r, filt_r) : filt_r;
  assign elapsed = now_r - last_close_r;
  assign close   = elapsed > period_r;
  assign seg_out = open_valid_r ? open_r : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    now_nxt        = now_r;
    prod_nxt       = prod_r;
    filt_nxt       = filt_r;
    filt_valid_nxt = filt_valid_r;
    open_nxt       = open_r;
    open_valid_nxt = open_valid_r;
    base_nxt       = base_r;
    base_valid_nxt = base_valid_r;
    ring_valid_nxt = ring_valid_r;
    pos_nxt        = pos_r;
    last_close_nxt = last_close_r;
    closed_nxt     = closed_r;
    scan_idx_nxt   = scan_idx_r;
    scan_issue_nxt = scan_issue_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = 1'b0;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = ext_new;
    ram_raddr      = scan_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata[DATA_W-1:0];
          now_nxt   = in_tdata[2*DATA_W-1:DATA_W];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(diff) * PROD_W'($signed({1'b0, gain_r}));
        state_nxt = S_FILT;
      end
      S_FILT: begin
        filt_nxt       = filt_valid_r ? y_sat : x_r;
        filt_valid_nxt = 1'b1;
        state_nxt      = S_FOLD;
      end
      S_FOLD: begin
        closed_nxt = close;
        if (close) begin
          // The open extremum, updated with this sample, goes into the ring; the baseline is rebuilt from scratch.
          ram_we                = 1'b1;
          ring_valid_nxt[pos_r] = 1'b1;
          pos_nxt               = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
          last_close_nxt        = now_r;
          open_nxt              = '0;
          open_valid_nxt        = 1'b0;
          base_nxt              = '0;
          base_valid_nxt        = 1'b0;
          scan_idx_nxt          = '0;
          scan_issue_nxt        = 1'b1;
          state_nxt             = S_SCAN;
        end else begin
          open_nxt       = ext_new;
          open_valid_nxt = 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_issue_r) begin
          rd_pend_nxt    = 1'b1;
          rd_idx_nxt     = scan_idx_r;
          scan_issue_nxt = (scan_idx_r != LAST_IDX);
          scan_idx_nxt   = scan_idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (ring_valid_r[rd_idx_r]) begin
            base_nxt       = base_valid_r ? pick(mode_r, base_r, ram_rdata) : ram_rdata;
            base_valid_nxt = 1'b1;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {base_valid_r ? base_r : seg_out, seg_out, filt_r};
          out_tuser_nxt = {closed_r, base_valid_r | open_valid_r, open_valid_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      filt_r       <= '0;
      filt_valid_r <= 1'b0;
      open_r       <= '0;
      open_valid_r <= 1'b0;
      base_r       <= '0;
      base_valid_r <= 1'b0;
      ring_valid_r <= '0;
      pos_r        <= '0;
      last_close_r <= '0;
      closed_r     <= 1'b0;
      scan_issue_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      filt_r       <= filt_nxt;
      filt_valid_r <= filt_valid_nxt;
      open_r       <= open_nxt;
      open_valid_r <= open_valid_nxt;
      base_r       <= base_nxt;
      base_valid_r <= base_valid_nxt;
      ring_valid_r <= ring_valid_nxt;
      pos_r        <= pos_nxt;
      last_close_r <= last_close_nxt;
      closed_r     <= closed_nxt;
      scan_issue_r <= scan_issue_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    now_r       <= now_nxt;
    prod_r      <= prod_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // A result held back by the sink keeps the block waiting in the output state.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result word overwritten while still pending");

  // A segment close always starts a ring scan.
  a_close_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD && close) |=> (state_r == S_SCAN && ring_valid_r != '0))
    else $error("segment close did not start the baseline scan");

  // At the end of a scan at least the freshly written slot has set the baseline.
  a_scan_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_pend_r && rd_idx_r == LAST_IDX) |=> base_valid_r)
    else $error("baseline invalid after ring scan");

  // No input word is taken while an item is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL && !in_tready))
    else $error("input accepted outside idle");

endmodule

>>> hdl/sweb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds the closed segment values of the ring.
`timescale 1ns / 1ps

module sweb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
